[src/ssa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the segment scatter-add unit.
// Used by the controller, the datapath, the top level and the checker.
package ssa_pkg;

  localparam int unsigned BIN_W    = 6;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned ADDR_W   = BIN_W + POS_W;
  localparam int unsigned DEPTH    = 1 << ADDR_W;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned NBINS_W  = 7;
  localparam int unsigned LLEN_W   = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [NBINS_W-1:0] NBINS_RESET = 7'd64;
  localparam logic [LLEN_W-1:0]  LLEN_RESET  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BINS  = 1'b0,
    REG_LAYER_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK  = 2'd0,
    ERR_BIN = 2'd1,
    ERR_POS = 2'd2
  } err_code_t;

  typedef enum logic {
    FUNC_ACC  = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic rd_en;
    logic wb;
  } ssa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } ssa_stat_t;

endpackage

[src/ssa_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the segment scatter-add unit.
// Depends on ssa_pkg for the command and status structs.
module ssa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ssa_pkg::ssa_stat_t stat,
  output ssa_pkg::ssa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WB    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // Hold the finished item until the output register can take it.
        if (!stat.out_busy) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

[src/ssa_dp.sv]
`timescale 1ns / 1ps
// Datapath of the segment scatter-add unit: configuration registers, input
// capture, the sum memory with its clearing sweep, saturating adder, output.
// Depends on ssa_pkg.
module ssa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssa_pkg::ssa_cmd_t                   cmd,
  output ssa_pkg::ssa_stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_func,
  input  logic signed [ssa_pkg::VALUE_W-1:0]  in_value,
  input  logic [ssa_pkg::BIN_W-1:0]           in_bin,
  input  logic [ssa_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssa_pkg::SUM_W-1:0]    out_sum,
  output logic [ssa_pkg::ERR_W-1:0]           out_error
);

  localparam int unsigned SW = ssa_pkg::SUM_W;
  localparam int unsigned VW = ssa_pkg::VALUE_W;

  logic [ssa_pkg::NBINS_W-1:0] num_bins_r;
  logic [ssa_pkg::LLEN_W-1:0]  layer_len_r;

  logic [ssa_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic [ssa_pkg::ADDR_W-1:0]  addr_r;
  logic                        func_r;
  logic signed [VW-1:0]        value_r;
  logic [ssa_pkg::ERR_W-1:0]   err_r;

  logic [SW-1:0] mem [ssa_pkg::DEPTH];
  logic [SW-1:0] rd_data_r;

  logic          out_valid_r;
  logic [SW-1:0] out_sum_r;
  logic [ssa_pkg::ERR_W-1:0] out_error_r;

  logic [ssa_pkg::ERR_W-1:0] err_nxt;
  logic signed [SW:0] acc_ext;
  logic [SW-1:0]      acc_sat;
  logic [SW-1:0]      wr_data;
  logic [SW-1:0]      res_sum;
  logic               item_ok;

  // Configuration registers; writes are always taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= ssa_pkg::NBINS_RESET;
      layer_len_r <= ssa_pkg::LLEN_RESET;
    end else if (cfg_valid) begin
      unique case (ssa_pkg::cfg_reg_t'(cfg_index))
        ssa_pkg::REG_NUM_BINS:  num_bins_r  <= cfg_data[ssa_pkg::NBINS_W-1:0];
        ssa_pkg::REG_LAYER_LEN: layer_len_r <= cfg_data[ssa_pkg::LLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Range checks. Register values above the store size cannot exclude a
  // legal field value, so a plain compare acts as the clamp.
  always_comb begin
    if ({1'b0, in_bin} >= num_bins_r) begin
      err_nxt = ssa_pkg::ERR_BIN;
    end else if ({1'b0, in_position} >= layer_len_r) begin
      err_nxt = ssa_pkg::ERR_POS;
    end else begin
      err_nxt = ssa_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_r  <= {in_bin, in_position};
      func_r  <= in_func;
      value_r <= in_value;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign item_ok = (err_r == ssa_pkg::ERR_OK);

  // 49-bit sum of the stored value and the element, clamped to 48 bits.
  assign acc_ext = $signed({rd_data_r[SW-1], rd_data_r})
                 + $signed({{(SW + 1 - VW){value_r[VW-1]}}, value_r});

  always_comb begin
    if (acc_ext[SW] != acc_ext[SW-1]) begin
      acc_sat = acc_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      acc_sat = acc_ext[SW-1:0];
    end
  end

  always_comb begin
    if (ssa_pkg::func_t'(func_r) == ssa_pkg::FUNC_READ) begin
      wr_data = '0;
      res_sum = rd_data_r;
    end else begin
      wr_data = acc_sat;
      res_sum = acc_sat;
    end
  end

  // Sum store: one write port (clearing sweep or write-back), one read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wb && item_ok) begin
      mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_sum_r   <= item_ok ? res_sum : '0;
      out_error_r <= err_r;
    end
  end

  assign stat.clr_last = &clr_cnt_r;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;
  assign out_error = out_error_r;

endmodule

[src/segment_scatter_add_unit.sv]
`timescale 1ns / 1ps
// Segment scatter-add unit: 64 bins x 256 positions of saturating 48-bit sums.
// An accumulate item adds a 32-bit value into one entry and returns the new
// sum; a read item returns one entry and clears it.
// Input channel (in_*): tdata carries value, bin, position; tuser carries func.
// Result channel (out_*): tdata carries the 48-bit sum; tuser the error code.
// Configuration channel (cfg_*): index 0 num_bins, index 1 layer_len; it is
// always ready.
// Flow: an accepted item is captured in the idle state, its entry is read into a
// register in the read state, and the write-back state then raises out_tvalid once
// the output register is free. The input is ready only in the idle state, so a new
// item is not accepted before the last one has been written back.
// Reset: after rst_n the sum memory is swept to zero, one entry a cycle, over
// all 16384 entries; in_tready stays low during the sweep.
// When the receiver stalls, the result holds in the output register and the
// next item may still be accepted and read; its write-back waits until the
// held result is taken.
// Depends on ssa_pkg, ssa_ctrl and ssa_dp.
module segment_scatter_add_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [31:0] value, [37:32] bin, [45:38] position, [47:46] zero
  input  logic [ssa_pkg::IN_TDATA_W-1:0]        in_tdata,
  // [0] func
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [47:0] sum
  output logic [ssa_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [1:0] error
  output logic [ssa_pkg::ERR_W-1:0]             out_tuser
);

  localparam int unsigned VW = ssa_pkg::VALUE_W;
  localparam int unsigned BW = ssa_pkg::BIN_W;
  localparam int unsigned PW = ssa_pkg::POS_W;

  ssa_pkg::ssa_cmd_t  cmd;
  ssa_pkg::ssa_stat_t stat;
  logic [ssa_pkg::SUM_W-1:0] sum;

  assign cfg_ready = 1'b1;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_func     (in_tuser),
    .in_value    (in_tdata[VW-1:0]),
    .in_bin      (in_tdata[VW+BW-1:VW]),
    .in_position (in_tdata[VW+BW+PW-1:VW+BW]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sum     (sum),
    .out_error   (out_tuser)
  );

  assign out_tdata = sum;

endmodule

[src/ssa_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the segment scatter-add unit, bound to the top level.
// Depends on ssa_pkg.
module ssa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [ssa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic [ssa_pkg::ERR_W-1:0]           out_tuser
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Items are taken one at a time: no acceptance in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // Only the defined error codes appear.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ssa_pkg::ERR_OK) || (out_tuser == ssa_pkg::ERR_BIN)
                   || (out_tuser == ssa_pkg::ERR_POS))
    else $error("undefined error code");

  // A rejected item reports a zero sum.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ssa_pkg::ERR_OK) |-> out_tdata == '0)
    else $error("nonzero sum with an error");

endmodule

bind segment_scatter_add_unit ssa_checker u_ssa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
